@@ src/jkv_pkg.sv @@
// Shared types and constants of the JSON key/value extractor.
`default_nettype none

package jkv_pkg;

    // Result queue geometry (depth is a power of two)
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = QUEUE_PW + 1;

    // Longest key the match logic compares
    localparam logic [4:0] KEY_MAX = 5'd16;

    // Configuration register indexes
    localparam logic [1:0] CFG_KEY_LOW  = 2'd0;
    localparam logic [1:0] CFG_KEY_HIGH = 2'd1;
    localparam logic [1:0] CFG_KEY_LEN  = 2'd2;

    // Result status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_NO_KEY     = 3'd1;
    localparam logic [2:0] ST_NO_COLON   = 3'd2;
    localparam logic [2:0] ST_NO_QUOTE   = 3'd3;
    localparam logic [2:0] ST_UNCLOSED   = 3'd4;
    localparam logic [2:0] ST_TOO_DEEP   = 3'd5;

    // One result item
    typedef struct packed {
        logic [7:0] value_byte;
        logic       has_byte;
        logic       value_last;
        logic [2:0] status;
    } t_result;

    // Results of one accepted byte, pushed into the queue together
    typedef struct packed {
        logic [1:0] cnt;
        t_result    r0;
        t_result    r1;
    } t_qwrite;

endpackage

`default_nettype wire

@@ src/jkv_front.sv @@
// Parser front end: key registers, key match, value framing and result generation.
`default_nettype none

module jkv_front
    import jkv_pkg::*;
#(
    parameter int DEPTH_MAX = 255
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last_byte,
    input  wire logic        i_room,
    output t_qwrite          o_qwr
);

    localparam int DW = $clog2(DEPTH_MAX + 1);

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;

    typedef enum logic [2:0] {
        PH_SEARCH,
        PH_MATCH,
        PH_COLON,
        PH_VALWS,
        PH_STRING,
        PH_BRACKET,
        PH_SCALAR,
        PH_DONE
    } t_phase;

    t_phase         r_phase, n_phase;
    logic [4:0]     r_match, n_match;
    logic [DW-1:0]  r_depth, n_depth;
    logic           r_brace, n_brace;
    logic [7:0]     r_held, n_held;
    logic           r_hv, n_hv;
    logic [63:0]    r_key_low;
    logic [63:0]    r_key_high;
    logic [4:0]     r_key_len;

    logic           accept;
    logic [4:0]     klen;
    logic [127:0]   key_all;
    logic [7:0]     key_byte;
    logic [7:0]     c;
    logic           is_ws;
    logic           is_open;
    logic           is_close;
    t_result        v_res [2];
    logic [1:0]     v_cnt;

    function automatic t_result mk_res(input logic [7:0] b, input logic has,
                                       input logic lst, input logic [2:0] st);
        t_result r;
        r.value_byte = b;
        r.has_byte   = has;
        r.value_last = lst;
        r.status     = st;
        return r;
    endfunction

    assign accept     = i_in_valid && i_room;
    assign o_in_stall = !i_room;
    assign c          = i_data_byte;

    // Clamp key length and pick the key character under comparison
    assign klen     = (r_key_len > KEY_MAX) ? KEY_MAX : r_key_len;
    assign key_all  = {r_key_high, r_key_low};
    assign key_byte = key_all[{r_match[3:0], 3'b000} +: 8];

    always_comb begin
        case (c) inside
            8'h20, [8'h09:8'h0D]: is_ws = 1'b1;
            default:              is_ws = 1'b0;
        endcase
    end

    assign is_open  = r_brace ? (c == CH_LBRACE) : (c == CH_LBRACK);
    assign is_close = r_brace ? (c == CH_RBRACE) : (c == CH_RBRACK);

    // Next parser state and the results caused by this byte
    always_comb begin
        n_phase  = r_phase;
        n_match  = r_match;
        n_depth  = r_depth;
        n_brace  = r_brace;
        n_held   = r_held;
        n_hv     = r_hv;
        v_cnt    = 2'd0;
        v_res[0] = '0;
        v_res[1] = '0;

        case (r_phase)
            PH_SEARCH: begin
                if (c == CH_QUOTE) begin
                    n_phase = PH_MATCH;
                    n_match = '0;
                end
            end
            PH_MATCH: begin
                if (r_match >= klen) begin
                    n_match = '0;
                    n_phase = (c == CH_QUOTE) ? PH_COLON : PH_SEARCH;
                end else if (c == key_byte) begin
                    n_match = r_match + 5'd1;
                end else begin
                    n_match = '0;
                    n_phase = (c == CH_QUOTE) ? PH_MATCH : PH_SEARCH;
                end
            end
            PH_COLON: begin
                if (c == CH_COLON) begin
                    n_phase = PH_VALWS;
                end else if (!is_ws) begin
                    v_res[v_cnt[0]] = mk_res(8'h00, 1'b0, 1'b1, ST_NO_COLON);
                    v_cnt   = v_cnt + 2'd1;
                    n_hv    = 1'b0;
                    n_held  = '0;
                    n_phase = PH_DONE;
                end
            end
            PH_VALWS: begin
                if (!is_ws) begin
                    if (c == CH_QUOTE) begin
                        n_phase = PH_STRING;
                    end else if (c == CH_LBRACE || c == CH_LBRACK) begin
                        // a parameter of at least one always admits the first level
                        n_phase = PH_BRACKET;
                        n_brace = (c == CH_LBRACE);
                        n_depth = DW'(1);
                        n_held  = c;
                        n_hv    = 1'b1;
                    end else if (c == CH_COMMA || c == CH_RBRACE || c == CH_RBRACK) begin
                        v_res[v_cnt[0]] = mk_res(8'h00, 1'b0, 1'b1, ST_OK);
                        v_cnt   = v_cnt + 2'd1;
                        n_hv    = 1'b0;
                        n_held  = '0;
                        n_phase = PH_DONE;
                    end else begin
                        n_phase = PH_SCALAR;
                        n_held  = c;
                        n_hv    = 1'b1;
                    end
                end
            end
            PH_STRING: begin
                if (c == CH_QUOTE) begin
                    v_res[v_cnt[0]] = mk_res(r_held, r_hv, 1'b1, ST_OK);
                    v_cnt   = v_cnt + 2'd1;
                    n_hv    = 1'b0;
                    n_held  = '0;
                    n_phase = PH_DONE;
                end else begin
                    if (r_hv) begin
                        v_res[v_cnt[0]] = mk_res(r_held, 1'b1, 1'b0, ST_OK);
                        v_cnt = v_cnt + 2'd1;
                    end
                    n_held = c;
                    n_hv   = 1'b1;
                end
            end
            PH_BRACKET: begin
                if (is_open && (r_depth >= DW'(DEPTH_MAX))) begin
                    v_res[v_cnt[0]] = mk_res(8'h00, 1'b0, 1'b1, ST_TOO_DEEP);
                    v_cnt   = v_cnt + 2'd1;
                    n_hv    = 1'b0;
                    n_held  = '0;
                    n_phase = PH_DONE;
                end else begin
                    // push this byte through the hold
                    if (r_hv) begin
                        v_res[v_cnt[0]] = mk_res(r_held, 1'b1, 1'b0, ST_OK);
                        v_cnt = v_cnt + 2'd1;
                    end
                    n_held = c;
                    n_hv   = 1'b1;
                    if (is_open) begin
                        n_depth = r_depth + DW'(1);
                    end else if (is_close) begin
                        if (r_depth != '0) begin
                            n_depth = r_depth - DW'(1);
                        end
                        if (n_depth == '0) begin
                            v_res[v_cnt[0]] = mk_res(c, 1'b1, 1'b1, ST_OK);
                            v_cnt   = v_cnt + 2'd1;
                            n_hv    = 1'b0;
                            n_held  = '0;
                            n_phase = PH_DONE;
                        end
                    end
                end
            end
            PH_SCALAR: begin
                if (c == CH_COMMA || c == CH_RBRACE || c == CH_RBRACK || is_ws) begin
                    v_res[v_cnt[0]] = mk_res(r_held, r_hv, 1'b1, ST_OK);
                    v_cnt   = v_cnt + 2'd1;
                    n_hv    = 1'b0;
                    n_held  = '0;
                    n_phase = PH_DONE;
                end else begin
                    if (r_hv) begin
                        v_res[v_cnt[0]] = mk_res(r_held, 1'b1, 1'b0, ST_OK);
                        v_cnt = v_cnt + 2'd1;
                    end
                    n_held = c;
                    n_hv   = 1'b1;
                end
            end
            default: begin
            end
        endcase

        // Close out the message on its final byte
        if (i_last_byte) begin
            case (n_phase)
                PH_SEARCH, PH_MATCH: begin
                    v_res[v_cnt[0]] = mk_res(8'h00, 1'b0, 1'b1, ST_NO_KEY);
                    v_cnt = v_cnt + 2'd1;
                end
                PH_COLON: begin
                    v_res[v_cnt[0]] = mk_res(8'h00, 1'b0, 1'b1, ST_NO_COLON);
                    v_cnt = v_cnt + 2'd1;
                end
                PH_VALWS, PH_SCALAR: begin
                    v_res[v_cnt[0]] = mk_res(n_held, n_hv, 1'b1, ST_OK);
                    v_cnt = v_cnt + 2'd1;
                end
                PH_STRING: begin
                    v_res[v_cnt[0]] = mk_res(8'h00, 1'b0, 1'b1, ST_NO_QUOTE);
                    v_cnt = v_cnt + 2'd1;
                end
                PH_BRACKET: begin
                    v_res[v_cnt[0]] = mk_res(8'h00, 1'b0, 1'b1, ST_UNCLOSED);
                    v_cnt = v_cnt + 2'd1;
                end
                default: begin
                end
            endcase
            n_phase = PH_SEARCH;
            n_match = '0;
            n_depth = '0;
            n_brace = 1'b0;
            n_held  = '0;
            n_hv    = 1'b0;
        end
    end

    // Hand this byte's results to the queue
    assign o_qwr.cnt = accept ? v_cnt : 2'd0;
    assign o_qwr.r0  = v_res[0];
    assign o_qwr.r1  = v_res[1];

    // Hold parser state and key registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_SEARCH;
            r_match    <= '0;
            r_depth    <= '0;
            r_brace    <= 1'b0;
            r_held     <= '0;
            r_hv       <= 1'b0;
            r_key_low  <= '0;
            r_key_high <= '0;
            r_key_len  <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_KEY_LOW:  r_key_low  <= i_cfg_data;
                    CFG_KEY_HIGH: r_key_high <= i_cfg_data;
                    CFG_KEY_LEN:  r_key_len  <= i_cfg_data[4:0];
                    default: begin
                    end
                endcase
            end
            if (accept) begin
                r_phase <= n_phase;
                r_match <= n_match;
                r_depth <= n_depth;
                r_brace <= n_brace;
                r_held  <= n_held;
                r_hv    <= n_hv;
            end
        end
    end

endmodule

`default_nettype wire

@@ src/jkv_queue.sv @@
// Result queue between parser and output stage: up to two writes, one read per cycle.
`default_nettype none

module jkv_queue
    import jkv_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_qwrite i_qwr,
    output logic         o_room,
    output logic         o_rd_valid,
    output t_result      o_rd_data,
    input  wire logic    i_rd_en
);

    t_result               r_mem [QUEUE_DEPTH];
    logic [QUEUE_PW-1:0]   r_wp;
    logic [QUEUE_PW-1:0]   r_rp;
    logic [QUEUE_CW-1:0]   r_count;
    logic                  rd;

    // Room for the worst case of two results from one byte
    assign o_room     = (r_count <= QUEUE_CW'(QUEUE_DEPTH - 2));
    assign o_rd_valid = (r_count != '0);
    assign o_rd_data  = r_mem[r_rp];
    assign rd         = i_rd_en && o_rd_valid;

    // Store incoming results
    always_ff @(posedge i_clk) begin
        if (i_qwr.cnt != 2'd0) begin
            r_mem[r_wp] <= i_qwr.r0;
        end
        if (i_qwr.cnt == 2'd2) begin
            r_mem[r_wp + QUEUE_PW'(1)] <= i_qwr.r1;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= r_wp + QUEUE_PW'(i_qwr.cnt);
            r_rp    <= r_rp + QUEUE_PW'(rd);
            r_count <= r_count + QUEUE_CW'(i_qwr.cnt) - QUEUE_CW'(rd);
        end
    end

endmodule

`default_nettype wire

@@ src/jkv_back.sv @@
// Output stage: registers one result and presents it on the result channel.
`default_nettype none

module jkv_back
    import jkv_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_q_valid,
    input  wire t_result i_q_data,
    output logic         o_q_pop,
    output logic         o_out_valid,
    input  wire logic    i_out_stall,
    output t_result      o_out_data
);

    logic    r_valid;
    t_result r_data;

    // Pull from the queue when the output register is empty or being taken
    assign o_q_pop     = i_q_valid && (!r_valid || !i_out_stall);
    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    // Hold the payload while stalled
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_data <= i_q_data;
        end
    end

endmodule

`default_nettype wire

@@ src/json_key_value_extractor_unit.sv @@
// Top level of the JSON key/value extractor.
//
// Input channel: one message byte per transfer (i_data_byte, i_last_byte), moved
// when i_in_valid is high and o_in_stall is low. Result channel: one result per
// transfer (o_value_byte, o_has_byte, o_value_last, o_status), moved when
// o_out_valid is high and i_out_stall is low. Each message ends with exactly one
// result that carries o_value_last.
// Configuration: i_cfg_valid/o_cfg_ready with i_cfg_index and i_cfg_data load the
// key low word, key high word and key length; o_cfg_ready is always high.
// Throughput: one byte per cycle. The parser updates its state in the cycle a byte
// is taken and pushes up to two results into a four-entry queue; it stalls input
// only while the queue has fewer than two free entries.
// Results of a byte are written into the queue when the byte is taken and then
// pass in order from the queue into the output register, which drains the queue
// at one result per cycle while the receiver does not stall.
// A receiver stall holds the result in place; the queue absorbs the next results
// and then the input stalls in turn.
// Reset (synchronous, active low) clears the parser, the key registers, the queue
// and the output register.
`default_nettype none

module json_key_value_extractor_unit
    import jkv_pkg::*;
#(
    parameter int DEPTH_MAX = 255
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [7:0]       o_value_byte,
    output logic             o_has_byte,
    output logic             o_value_last,
    output logic [2:0]       o_status
);

    t_qwrite qwr;
    logic    room;
    logic    q_valid;
    t_result q_data;
    logic    q_pop;
    t_result out_data;

    assign o_cfg_ready = 1'b1;

    jkv_front #(
        .DEPTH_MAX (DEPTH_MAX)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_room      (room),
        .o_qwr       (qwr)
    );

    jkv_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_qwr      (qwr),
        .o_room     (room),
        .o_rd_valid (q_valid),
        .o_rd_data  (q_data),
        .i_rd_en    (q_pop)
    );

    jkv_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_data    (q_data),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (out_data)
    );

    assign o_value_byte = out_data.value_byte;
    assign o_has_byte   = out_data.has_byte;
    assign o_value_last = out_data.value_last;
    assign o_status     = out_data.status;

endmodule

`default_nettype wire
